// ----- sv/lds_pkg.sv -----
// package for the largest divisible subset block
// types and constants shared by the divider, top level and checker; no dependencies
package lds_pkg;
  localparam int MaxItems = 32;
  localparam int IdxW = $clog2(MaxItems);
  localparam int CntW = $clog2(MaxItems + 1);
  localparam int ValW = 31;

  // request and reply of the shared remainder unit
  typedef struct packed {
    logic            start;
    logic [ValW-1:0] dividend;
    logic [ValW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic zero_rem;
  } div_rsp_t;
endpackage

// ----- sv/lds_ram.sv -----
// generic single port ram with registered read
// no dependencies
module lds_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- sv/lds_div.sv -----
// bit-serial restoring remainder unit, one quotient bit per cycle
// depends on lds_pkg
module lds_div (
  input  logic             clk,
  input  logic             rst,
  input  lds_pkg::div_req_t req,
  output lds_pkg::div_rsp_t rsp
);
  localparam int W = lds_pkg::ValW;

  logic [W-1:0] dvd;
  logic [W-1:0] dvs;
  logic [W:0]   rem;
  logic [$clog2(W+1)-1:0] cnt;
  logic         busy;
  logic         done;
  logic [W:0]   trial;
  logic [W:0]   shifted;

  always_comb begin
    shifted = {rem[W-1:0], dvd[W-1]};
    trial   = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        rem <= trial[W] ? shifted : trial;
        dvd <= {dvd[W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(W+1))'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, zero_rem: (rem == '0)};
endmodule

// ----- sv/largest_divisible_subset_top.sv -----
// largest divisible subset, top level: load sequencer, chain dp, emitter
// depends on lds_pkg, lds_ram, lds_div
//
// usage
//   input channel s_axis: tdata holds value, tlast marks the last value of a set.
//   output channel m_axis: tdata holds member, tlast marks the final member,
//   tuser holds the overflow flag of the set.
//   values are kept sorted by insertion; each load reads and shifts up every
//   stored value that is greater than the new one.
//   on the last beat the chain dp runs over all pairs j<i; each pair takes
//   a ram read, an operand hand-off and a remainder in the shared unit.
//   the chain is then walked backwards into a small buffer and emitted in
//   ascending order, one beat per cycle when ready.
//   s_axis tready is low for the whole of this work; only one set is worked on
//   at a time.
//   values beyond 32 are dropped and overflow is set on every member of the set.
//   a stalled receiver simply holds the output beat; nothing is lost.
//   reset clears the sequencer and counts; the stores need no clearing.
module largest_divisible_subset_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] value, [31] zero
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [30:0] member, [31] zero
  output logic        m_axis_tlast,   // final_res
  output logic        m_axis_tuser    // overflow
);
  localparam int IW = lds_pkg::IdxW;
  localparam int CW = lds_pkg::CntW;
  localparam int VW = lds_pkg::ValW;
  localparam int N  = lds_pkg::MaxItems;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_INS_R = 13'b0000000000010, // read entry pos-1
    S_INS_C = 13'b0000000000100, // compare and shift up
    S_I_RD  = 13'b0000000001000, // read value i
    S_I_LAT = 13'b0000000010000,
    S_J_RD  = 13'b0000000100000, // read value and length j
    S_J_DIV = 13'b0000001000000, // wait for remainder
    S_I_WR  = 13'b0000010000000, // write length and predecessor of i
    S_W_RD  = 13'b0000100000000, // backtrack read
    S_W_LAT = 13'b0001000000000,
    S_OUT   = 13'b0010000000000,
    S_LEN   = 13'b0100000000000, // read best length
    S_LEN_L = 13'b1000000000000
  } state_t;

  state_t state;

  // stores
  logic          v_we, m_we;
  logic [IW-1:0] v_addr, m_addr;
  logic [VW-1:0] v_wdata, v_rdata;
  logic [2*CW-1:0] m_wdata, m_rdata; // {length, predecessor}

  lds_ram #(.Width(VW), .Depth(N)) u_vals (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata)
  );
  lds_ram #(.Width(2*CW), .Depth(N)) u_meta (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
  );

  lds_pkg::div_req_t div_req;
  lds_pkg::div_rsp_t div_rsp;
  lds_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  logic [CW-1:0] count;
  logic          dropped;
  logic          run_after;  // last seen on the value being inserted
  logic [VW-1:0] new_val;
  logic [CW-1:0] pos;
  logic [CW-1:0] i, j;
  logic [VW-1:0] vi, vj;
  logic [CW-1:0] len_i, pred_i, len_j;
  logic [CW-1:0] best_len;
  logic [IW-1:0] best_end;
  logic [IW-1:0] idx;
  logic [CW-1:0] k, out_len, out_k;
  logic [VW-1:0] chain [N];     // output buffer, one slot per chain member
  logic          div_wait;
  logic          div_busy_q;
  logic          div_go;

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;

  always_comb begin
    v_we    = 1'b0;
    v_addr  = '0;
    v_wdata = new_val;
    m_we    = 1'b0;
    m_addr  = '0;
    m_wdata = {len_i, pred_i};
    case (state)
      S_INS_R: v_addr = IW'(pos - 1'b1);
      S_INS_C: begin
        if (pos != '0 && v_rdata > new_val) begin
          v_addr = pos[IW-1:0];
          v_wdata = v_rdata;
        end else begin
          v_addr = pos[IW-1:0];
        end
        v_we = 1'b1;
      end
      S_I_RD, S_I_LAT: v_addr = i[IW-1:0];
      S_J_RD, S_J_DIV: begin
        v_addr = j[IW-1:0];
        m_addr = j[IW-1:0];
      end
      S_I_WR: begin
        m_addr = i[IW-1:0];
        m_we   = 1'b1;
      end
      S_LEN, S_LEN_L: m_addr = best_end;
      S_W_RD, S_W_LAT: begin
        v_addr = idx;
        m_addr = idx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      dropped       <= 1'b0;
      m_axis_tvalid <= 1'b0;
      best_end      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (m_axis_tvalid) begin
            if (m_axis_tready) begin
              if (out_k + 1'b1 == out_len) begin
                m_axis_tvalid <= 1'b0;
                count   <= '0;
                dropped <= 1'b0;
              end else begin
                out_k        <= out_k + 1'b1;
                m_axis_tdata <= {1'b0, chain[IW'(out_k + 1'b1)]};
                m_axis_tlast <= (out_k + 2'd2 == out_len);
              end
            end
          end else if (s_axis_tvalid) begin
            new_val   <= s_axis_tdata[VW-1:0];
            run_after <= s_axis_tlast;
            if (count == CW'(N)) begin
              dropped <= 1'b1;
              if (s_axis_tlast) begin
                i <= '0; best_len <= '0; best_end <= '0;
                state <= S_I_RD;
              end
            end else begin
              pos   <= count;
              state <= (count == '0) ? S_INS_C : S_INS_R;
            end
          end
        end
        S_INS_R: state <= S_INS_C;
        S_INS_C: begin
          if (pos != '0 && v_rdata > new_val) begin
            pos   <= pos - 1'b1;
            state <= (pos == CW'(1)) ? S_INS_C : S_INS_R;
          end else begin
            count <= count + 1'b1;
            if (run_after) begin
              i <= '0; best_len <= '0; best_end <= '0;
              state <= S_I_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_I_RD: begin
          if (i == count) begin
            state <= S_LEN;
          end else begin
            state <= S_I_LAT;
          end
        end
        S_I_LAT: begin
          vi     <= v_rdata;
          len_i  <= CW'(1);
          pred_i <= i;
          j      <= '0;
          state  <= (i == '0) ? S_I_WR : S_J_RD;
        end
        S_J_RD: begin
          div_wait <= 1'b0;
          state    <= S_J_DIV;
        end
        S_J_DIV: begin
          if (!div_wait) begin
            vj     <= v_rdata;
            len_j  <= m_rdata[2*CW-1:CW];
            div_wait <= 1'b1;
          end else if (div_rsp.done) begin
            if (vj != '0 && div_rsp.zero_rem && len_j + 1'b1 > len_i) begin
              len_i  <= len_j + 1'b1;
              pred_i <= j;
            end
            j <= j + 1'b1;
            state <= (j + 1'b1 == i) ? S_I_WR : S_J_RD;
          end
        end
        S_I_WR: begin
          if (len_i > best_len) begin
            best_len <= len_i;
            best_end <= i[IW-1:0];
          end
          i     <= i + 1'b1;
          state <= S_I_RD;
        end
        S_LEN: state <= S_LEN_L;
        S_LEN_L: begin
          out_len <= best_len;
          k       <= best_len;
          idx     <= best_end;
          state   <= S_W_RD;
        end
        S_W_RD: state <= S_W_LAT;
        S_W_LAT: begin
          chain[IW'(k - 1'b1)] <= v_rdata;
          idx <= m_rdata[IW-1:0];
          k   <= k - 1'b1;
          state <= (k == CW'(1)) ? S_OUT : S_W_RD;
        end
        S_OUT: begin
          out_k         <= '0;
          m_axis_tdata  <= {1'b0, chain[0]};
          m_axis_tlast  <= (out_len == CW'(1));
          m_axis_tuser  <= dropped;
          m_axis_tvalid <= 1'b1;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // start pulse for the remainder unit once operands are latched
  assign div_go = (state == S_J_DIV) && div_wait && !div_busy_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy_q <= 1'b0;
    end else if (state == S_J_DIV && !div_wait) begin
      div_busy_q <= 1'b0;
    end else if (div_go) begin
      div_busy_q <= 1'b1;
    end
  end

  // a zero divisor never counts, so divide by one to keep the unit defined
  always_comb begin
    div_req.start    = div_go;
    div_req.dividend = vi;
    div_req.divisor  = (vj == '0) ? VW'(1) : vj;
  end
endmodule

// ----- verif/largest_divisible_subset_checker.sv -----
// checker for the largest divisible subset block: watches both streams,
// predicts each set's chain and compares every output beat; depends on lds_pkg
module largest_divisible_subset_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        m_axis_tuser,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  localparam int ValW = lds_pkg::ValW;
  localparam int MaxItems = lds_pkg::MaxItems;

  typedef struct packed {
    logic [ValW-1:0] member;
    logic            final_res;
    logic            overflow;
  } member_beat_t;

  logic [ValW-1:0] set_vals[MaxItems];
  int              set_count;
  logic            set_dropped;
  member_beat_t    chain_q[$];

  task automatic add_value(input logic [ValW-1:0] v);
    int p;
    if (set_count >= MaxItems) begin
      set_dropped = 1'b1;
      return;
    end
    p = set_count;
    while (p > 0 && set_vals[p-1] > v) begin
      set_vals[p] = set_vals[p-1];
      p--;
    end
    set_vals[p] = v;
    set_count++;
  endtask

  // longest divisor chain, first best predecessor and first best end
  task automatic predict_chain();
    int len[MaxItems];
    int prev[MaxItems];
    int best, n, idx;
    logic [ValW-1:0] chain[MaxItems];
    member_beat_t b;
    best = 0;
    for (int i = 0; i < set_count; i++) begin
      len[i] = 1;
      prev[i] = i;
      for (int j = 0; j < i; j++)
        if (set_vals[j] != 0 && set_vals[i] % set_vals[j] == 0 && len[j] + 1 > len[i]) begin
          len[i] = len[j] + 1;
          prev[i] = j;
        end
      if (len[i] > len[best]) best = i;
    end
    n = len[best];
    idx = best;
    for (int k = n; k > 0; k--) begin
      chain[k-1] = set_vals[idx];
      idx = prev[idx];
    end
    for (int k = 0; k < n; k++) begin
      b.member = chain[k];
      b.final_res = (k == n - 1);
      b.overflow = set_dropped;
      chain_q = {chain_q, b};
    end
    set_count = 0;
    set_dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    member_beat_t want;
    if (rst) begin
      set_count = 0;
      set_dropped = 1'b0;
      pending = 0;
      fail_count <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (chain_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected beat: member %0d last %b ovf %b",
                     m_axis_tdata[ValW-1:0], m_axis_tlast, m_axis_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = chain_q.pop_front();
          if (m_axis_tdata !== {1'b0, want.member} || m_axis_tlast !== want.final_res ||
              m_axis_tuser !== want.overflow) begin
            if (fail_count < 10)
              $display("mismatch: want member %0d last %b ovf %b, got %0d %b %b (top bit %b)",
                       want.member, want.final_res, want.overflow,
                       m_axis_tdata[ValW-1:0], m_axis_tlast, m_axis_tuser,
                       m_axis_tdata[31]);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        add_value(s_axis_tdata[ValW-1:0]);
        if (s_axis_tlast) predict_chain();
      end
      pending = chain_q.size();
    end
  end
endmodule

// ----- verif/largest_divisible_subset_top_test.sv -----
// testbench top for the largest divisible subset block: drives sets of values,
// stalls the output at random and gives the verdict; depends on the checker and the top level
module largest_divisible_subset_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogCycles = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [30:0] value, [31] zero
  logic        s_axis_tlast = 1'b0; // last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [30:0] member, [31] zero
  logic        m_axis_tlast;        // final_res
  logic        m_axis_tuser;        // overflow
  int          fail_count;
  int          pending;
  int          idle_cycles;
  int          items_sent;
  int          stall_left;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  largest_divisible_subset_top dut (.*);

  largest_divisible_subset_checker chk (.*);

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // random stalls on the output side
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left    <= gap_len();
    end
  end

  // watchdog: no beat accepted for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogCycles) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // called at a falling edge; leaves tvalid high after the accepting edge
  task automatic send_beat(input logic [30:0] v, input logic lst);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_axis_tdata <= {1'b0, v};
    s_axis_tlast <= lst;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // value from a small base times powers so that chains actually form
  function automatic logic [30:0] chain_value(input logic [30:0] base);
    logic [30:0] v;
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 31'($urandom_range(1, 32'h7fffffff));
    if (r == 1) return 31'h7fffffff;
    v = base;
    repeat ($urandom_range(0, 6)) v = 31'(v * $urandom_range(1, 5));
    return (v == 0) ? 31'd1 : v;
  endfunction

  initial begin
    int n;
    logic [30:0] base;
    items_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: lone value, extremes, equal values, a clear chain
    send_beat(31'd1, 1'b1);
    send_beat(31'h7fffffff, 1'b1);
    send_beat(31'd7, 1'b0);
    send_beat(31'd7, 1'b1);
    send_beat(31'd12, 1'b0);
    send_beat(31'd3, 1'b0);
    send_beat(31'd6, 1'b0);
    send_beat(31'd5, 1'b0);
    send_beat(31'd1, 1'b1);
    send_beat(31'h40000000, 1'b0);
    send_beat(31'h2aaaaaaa, 1'b0);
    send_beat(31'h55555555, 1'b1);
    // overflow: more than the store holds, dropped value carries last
    for (int i = 0; i < 34; i++) send_beat(31'd1 << (i % 31), i == 33);

    while (items_sent < 470) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
      base = 31'($urandom_range(1, 20));
      for (int i = 0; i < n; i++) send_beat(chain_value(base), i == n - 1);
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
